>>> rtl/asu_pkg.sv
// shared types, constants and helpers for the converter scan block
`default_nettype none

package asu_pkg;

  localparam int unsigned SampleW   = 10;
  localparam int unsigned PointW    = 8;
  localparam int unsigned CurveRegW = 40;
  localparam int unsigned ThrW      = 8;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 5;
  localparam int unsigned RegIdxW  = 2;

  // register indexes, byte address is 8 times the index
  localparam logic [RegIdxW-1:0] REG_CURVE_IN  = 2'd0;
  localparam logic [RegIdxW-1:0] REG_CURVE_OUT = 2'd1;
  localparam logic [RegIdxW-1:0] REG_FLUSH_THR = 2'd2;

  localparam logic [CurveRegW-1:0] CurveInRst  = 40'hFF_BF7F_3C00;
  localparam logic [CurveRegW-1:0] CurveOutRst = 40'hFE_E6BE_7F32;
  localparam logic [ThrW-1:0]      FlushThrRst = 8'd187;

  localparam logic [PointW-1:0] PointMax = 8'hFF;

  // converter channel select codes
  localparam logic CH_MODE = 1'b0;
  localparam logic CH_RATE = 1'b1;

  typedef struct packed {
    logic              start;
    logic [PointW-1:0] x;
  } crv_req_t;

  typedef struct packed {
    logic              done;
    logic [PointW-1:0] code;
  } crv_rsp_t;

  // breakpoint k of a packed register, zero past its top byte
  function automatic logic [PointW-1:0] point_byte(input logic [CurveRegW-1:0] r,
                                                   input int unsigned k);
    logic [CurveRegW-1:0] s;
    s = r >> (PointW * k);
    return s[PointW-1:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/asu_if.sv
// valid/ready channel interfaces for conversion beats and update beats
`default_nettype none

interface asu_in_if import asu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] conversion_result;

  modport source (output valid, output conversion_result, input ready);
  modport sink   (input valid, input conversion_result, output ready);
endinterface

interface asu_out_if import asu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              flush_pulse;
  logic              rate_update;
  logic [PointW-1:0] rate_code;
  logic              mode_update;
  logic [PointW-1:0] mode_code;
  logic              next_channel;

  modport source (output valid, output flush_pulse, output rate_update, output rate_code,
                  output mode_update, output mode_code, output next_channel, input ready);
  modport sink   (input valid, input flush_pulse, input rate_update, input rate_code,
                  input mode_update, input mode_code, input next_channel, output ready);
endinterface

`default_nettype wire

>>> rtl/asu_cfg.sv
// apb register file: curve breakpoints and flush threshold
`default_nettype none

module asu_cfg import asu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CfgAddrW-1:0]  paddr,
  input  logic [CfgDataW-1:0]  pwdata,
  output logic [CfgDataW-1:0]  prdata,
  output logic                 pready,
  output logic [CurveRegW-1:0] curve_in_o,
  output logic [CurveRegW-1:0] curve_out_o,
  output logic [ThrW-1:0]      flush_thr_o
);

  logic [CurveRegW-1:0] curve_in_q;
  logic [CurveRegW-1:0] curve_out_q;
  logic [ThrW-1:0]      flush_thr_q;
  logic [RegIdxW-1:0]   reg_idx;
  logic                 wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CfgAddrW-1:CfgAddrW-RegIdxW];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      curve_in_q  <= CurveInRst;
      curve_out_q <= CurveOutRst;
      flush_thr_q <= FlushThrRst;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CURVE_IN:  curve_in_q  <= pwdata[CurveRegW-1:0];
        REG_CURVE_OUT: curve_out_q <= pwdata[CurveRegW-1:0];
        REG_FLUSH_THR: flush_thr_q <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CURVE_IN:  prdata = CfgDataW'(curve_in_q);
      REG_CURVE_OUT: prdata = CfgDataW'(curve_out_q);
      REG_FLUSH_THR: prdata = CfgDataW'(flush_thr_q);
      default:       prdata = '0;
    endcase
  end

  assign curve_in_o  = curve_in_q;
  assign curve_out_o = curve_out_q;
  assign flush_thr_o = flush_thr_q;

endmodule

`default_nettype wire

>>> rtl/asu_curve.sv
// piecewise-linear curve: serial segment search, one multiply, serial restoring divide
`default_nettype none

module asu_curve import asu_pkg::*; #(
  parameter int unsigned CURVE_POINTS = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [CurveRegW-1:0] curve_in_i,
  input  logic [CurveRegW-1:0] curve_out_i,
  input  crv_req_t             req_i,
  output crv_rsp_t             rsp_o
);

  localparam int unsigned SegW  = (CURVE_POINTS > 2) ? $clog2(CURVE_POINTS - 1) : 1;
  localparam int unsigned ProdW = 2 * PointW;
  localparam int unsigned CntW  = $clog2(ProdW);
  localparam logic [SegW-1:0] LastSeg  = SegW'(CURVE_POINTS - 2);
  localparam logic [CntW-1:0] LastStep = CntW'(ProdW - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [SegW-1:0]   seg_q;
  logic [CntW-1:0]   cnt_q;
  logic [PointW-1:0] x_q;
  logic [PointW-1:0] in_sh_q  [CURVE_POINTS];
  logic [PointW-1:0] out_sh_q [CURVE_POINTS];
  logic [PointW-1:0] in_lo_q, in_hi_q, out_lo_q, out_hi_q;
  logic [PointW-1:0] den_q;
  logic              neg_q;
  logic [PointW-1:0] rem_q;
  logic [ProdW-1:0]  quo_q;

  logic              hit;
  logic              last_seg;
  logic [PointW-1:0] dx, dmag, den;
  logic              dneg;
  logic [ProdW-1:0]  prod;
  logic [PointW:0]   trial;
  logic              ge;
  logic [PointW:0]   diff;

  // segment test on the two breakpoints at the head of the shift line
  assign hit      = (x_q >= in_sh_q[0]) && (x_q <= in_sh_q[1]);
  assign last_seg = (seg_q == LastSeg);

  assign dx   = x_q - in_lo_q;
  assign dneg = out_hi_q < out_lo_q;
  assign dmag = dneg ? (out_lo_q - out_hi_q) : (out_hi_q - out_lo_q);
  assign den  = in_hi_q - in_lo_q;
  assign prod = ProdW'(dx) * ProdW'(dmag);

  // one restoring step per cycle, remainder always below the divisor
  assign trial = {rem_q, quo_q[ProdW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req_i.start) state_d = S_SRCH;
      S_SRCH: if (hit || last_seg) state_d = S_MUL;
      S_MUL:  state_d = (den == '0) ? S_FIN : S_DIV;
      S_DIV:  if (cnt_q == LastStep) state_d = S_FIN;
      S_FIN:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      seg_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: seg_q <= '0;
        S_SRCH: seg_q <= seg_q + SegW'(1);
        S_MUL:  cnt_q <= '0;
        S_DIV:  cnt_q <= cnt_q + CntW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          x_q <= req_i.x;
          for (int unsigned k = 0; k < CURVE_POINTS; k++) begin
            in_sh_q[k]  <= point_byte(curve_in_i, k);
            out_sh_q[k] <= point_byte(curve_out_i, k);
          end
        end
      end
      S_SRCH: begin
        if (hit) begin
          in_lo_q  <= in_sh_q[0];
          in_hi_q  <= in_sh_q[1];
          out_lo_q <= out_sh_q[0];
          out_hi_q <= out_sh_q[1];
        end else if (last_seg) begin
          // no segment holds the value: identity line
          in_lo_q  <= '0;
          in_hi_q  <= PointMax;
          out_lo_q <= '0;
          out_hi_q <= PointMax;
        end else begin
          for (int unsigned k = 0; k + 1 < CURVE_POINTS; k++) begin
            in_sh_q[k]  <= in_sh_q[k+1];
            out_sh_q[k] <= out_sh_q[k+1];
          end
          in_sh_q[CURVE_POINTS-1]  <= '0;
          out_sh_q[CURVE_POINTS-1] <= '0;
        end
      end
      S_MUL: begin
        den_q <= den;
        neg_q <= dneg;
        rem_q <= '0;
        // zero-width segment leaves a zero quotient, giving the lower output
        quo_q <= (den == '0) ? '0 : prod;
      end
      S_DIV: begin
        rem_q <= ge ? diff[PointW-1:0] : trial[PointW-1:0];
        quo_q <= {quo_q[ProdW-2:0], ge};
      end
      default: ;
    endcase
  end

  assign rsp_o.done = (state_q == S_FIN);
  assign rsp_o.code = neg_q ? (out_lo_q - quo_q[PointW-1:0])
                            : (out_lo_q + quo_q[PointW-1:0]);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == S_IDLE)
    else $error("curve start while busy");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < den_q)
    else $error("divider remainder out of range");

  a_fin_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FIN |-> $past(state_q) == S_DIV || $past(state_q) == S_MUL)
    else $error("curve result without divide");

endmodule

`default_nettype wire

>>> rtl/adc_scan_calibrated_update.sv
// top level: converter scan sequencing, update detection and output staging
//
// Takes one finished 10-bit conversion per input beat and returns exactly one
// update beat for it. Conversions alternate between discarded and used, the
// first after reset used; the scan order is rate, rate, then mode and rate in
// turn, and next_channel tells which channel to convert next. A discarded
// conversion, a used mode conversion or an unchanged rate value goes from the
// staging register to the output register without the curve. A used rate
// conversion whose value changed runs the calibration curve on one shared
// engine: segment search over up to CURVE_POINTS-1 segments (one breakpoint
// pair per cycle), one multiply, a restoring divide of the 16-bit product,
// the offset add, and the hand-over of the code through the staging register
// to the output register. One item is worked at a time; the next beat is
// taken as soon as the previous result has moved into the output register,
// which may still wait for the sink.
`default_nettype none

module adc_scan_calibrated_update import asu_pkg::*; #(
  parameter int unsigned CURVE_POINTS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  asu_in_if.sink              conv_i,
  asu_out_if.source           upd_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic [CurveRegW-1:0] curve_in, curve_out;
  logic [ThrW-1:0]      flush_thr;
  crv_req_t             crv_req;
  crv_rsp_t             crv_rsp;

  // scan state
  logic              skip_q, skip_d;
  logic              seq_q, seq_d;
  logic              chan_q, chan_d;
  logic [PointW-1:0] rate_val_q, rate_val_d;
  logic [PointW-1:0] mode_val_q, mode_val_d;

  // result staging ahead of the output register
  logic              r_full_q, r_wait_q;
  logic              r_flush_q, r_rate_up_q, r_mode_up_q, r_next_q;
  logic [PointW-1:0] r_rate_code_q, r_mode_code_q;

  logic              o_valid_q;
  logic              o_flush_q, o_rate_up_q, o_mode_up_q, o_next_q;
  logic [PointW-1:0] o_rate_code_q, o_mode_code_q;

  logic              accept, move;
  logic [PointW-1:0] sample_v;
  logic              flush, rate_up, mode_up;

  asu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .curve_in_o  (curve_in),
    .curve_out_o (curve_out),
    .flush_thr_o (flush_thr)
  );

  asu_curve #(
    .CURVE_POINTS (CURVE_POINTS)
  ) u_curve (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .curve_in_i  (curve_in),
    .curve_out_i (curve_out),
    .req_i       (crv_req),
    .rsp_o       (crv_rsp)
  );

  assign conv_i.ready = !r_full_q;
  assign accept       = conv_i.valid && conv_i.ready;
  assign move         = r_full_q && !r_wait_q && (!o_valid_q || upd_o.ready);
  assign sample_v     = conv_i.conversion_result[SampleW-1:SampleW-PointW];

  always_comb begin
    skip_d     = skip_q;
    seq_d      = seq_q;
    chan_d     = chan_q;
    rate_val_d = rate_val_q;
    mode_val_d = mode_val_q;
    flush      = 1'b0;
    rate_up    = 1'b0;
    mode_up    = 1'b0;
    if (skip_q) begin
      flush  = (chan_q == CH_RATE) && (rate_val_q < flush_thr);
      skip_d = 1'b0;
    end else begin
      if (chan_q == CH_RATE) begin
        rate_up    = sample_v != rate_val_q;
        rate_val_d = sample_v;
      end else begin
        mode_up    = sample_v != mode_val_q;
        mode_val_d = sample_v;
      end
      seq_d  = !seq_q;
      chan_d = seq_d ? CH_RATE : CH_MODE;
      skip_d = 1'b1;
    end
  end

  assign crv_req.start = accept && rate_up;
  assign crv_req.x     = sample_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q     <= 1'b0;
      seq_q      <= 1'b0;
      chan_q     <= CH_RATE;
      rate_val_q <= '0;
      mode_val_q <= '0;
      r_full_q   <= 1'b0;
      r_wait_q   <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        skip_q     <= skip_d;
        seq_q      <= seq_d;
        chan_q     <= chan_d;
        rate_val_q <= rate_val_d;
        mode_val_q <= mode_val_d;
        r_full_q   <= 1'b1;
        r_wait_q   <= rate_up;
      end else begin
        if (crv_rsp.done) r_wait_q <= 1'b0;
        if (move) r_full_q <= 1'b0;
      end
      if (move) begin
        o_valid_q <= 1'b1;
      end else if (upd_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_flush_q     <= flush;
      r_rate_up_q   <= rate_up;
      r_rate_code_q <= '0;
      r_mode_up_q   <= mode_up;
      r_mode_code_q <= mode_up ? sample_v : '0;
      r_next_q      <= chan_d;
    end else if (crv_rsp.done) begin
      r_rate_code_q <= crv_rsp.code;
    end
    if (move) begin
      o_flush_q     <= r_flush_q;
      o_rate_up_q   <= r_rate_up_q;
      o_rate_code_q <= r_rate_code_q;
      o_mode_up_q   <= r_mode_up_q;
      o_mode_code_q <= r_mode_code_q;
      o_next_q      <= r_next_q;
    end
  end

  assign upd_o.valid        = o_valid_q;
  assign upd_o.flush_pulse  = o_flush_q;
  assign upd_o.rate_update  = o_rate_up_q;
  assign upd_o.rate_code    = o_rate_code_q;
  assign upd_o.mode_update  = o_mode_up_q;
  assign upd_o.mode_code    = o_mode_code_q;
  assign upd_o.next_channel = o_next_q;

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crv_rsp.done |-> r_wait_q)
    else $error("curve result with no pending item");

  a_wait_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_wait_q |-> r_full_q && !move)
    else $error("pending curve result without a staged item");

  a_used_no_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !skip_q |=> !r_flush_q)
    else $error("flush on a used conversion");

endmodule

`default_nettype wire

>>> bench/asu_checker.sv
// checker for the converter scan block: mirrors its registers, predicts each update beat and compares

module asu_checker import asu_pkg::*; #(
  parameter int unsigned CURVE_POINTS = 5
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  asu_in_if                   conv_i,
  asu_out_if                  upd_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [CfgAddrW-1:0] paddr_i,
  input  logic [CfgDataW-1:0] pwdata_i,
  output int                  pending_o,
  output int                  err_count_o
);

  typedef struct packed {
    logic              flush;
    logic              rate_up;
    logic [PointW-1:0] rate_code;
    logic              mode_up;
    logic [PointW-1:0] mode_code;
    logic              next_ch;
  } update_beat_t;

  update_beat_t pending_updates [$];

  logic [CurveRegW-1:0] crv_in;
  logic [CurveRegW-1:0] crv_out;
  logic [ThrW-1:0]      flush_thr;

  logic              skip_conv;
  logic              scan_idx;
  logic              cur_chan;
  logic [PointW-1:0] last_rate;
  logic [PointW-1:0] last_mode;
  int                errs;

  // breakpoints past the fifth read as zero
  function automatic int breakpoint(input logic [CurveRegW-1:0] r, input int k);
    if (k >= 5) return 0;
    return int'((r >> (PointW * k)) & 40'hFF);
  endfunction

  function automatic logic [PointW-1:0] calibrate_rate(input logic [PointW-1:0] x);
    int xi, a, b, lo_in, hi_in, lo_out, hi_out, r;
    bit found;
    xi = int'(x);
    lo_in = 0;
    hi_in = 255;
    lo_out = 0;
    hi_out = 255;
    found = 1'b0;
    for (int i = 0; i + 1 < CURVE_POINTS; i++) begin
      a = breakpoint(crv_in, i);
      b = breakpoint(crv_in, i + 1);
      if (!found && xi >= a && xi <= b) begin
        found = 1'b1;
        lo_in = a;
        hi_in = b;
        lo_out = breakpoint(crv_out, i);
        hi_out = breakpoint(crv_out, i + 1);
      end
    end
    // zero-width segment takes its lower output
    if (hi_in == lo_in) return lo_out[PointW-1:0];
    r = lo_out + ((xi - lo_in) * (hi_out - lo_out)) / (hi_in - lo_in);
    return r[PointW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    update_beat_t exp_beat;
    update_beat_t got_beat;
    logic [PointW-1:0] v;
    if (!rst_ni) begin
      crv_in = CurveInRst;
      crv_out = CurveOutRst;
      flush_thr = FlushThrRst;
      skip_conv = 1'b0;
      scan_idx = 1'b0;
      cur_chan = CH_RATE;
      last_rate = '0;
      last_mode = '0;
      errs = 0;
      pending_updates.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[CfgAddrW-1:3])
          REG_CURVE_IN:  crv_in = pwdata_i[CurveRegW-1:0];
          REG_CURVE_OUT: crv_out = pwdata_i[CurveRegW-1:0];
          REG_FLUSH_THR: flush_thr = pwdata_i[ThrW-1:0];
          default: ;
        endcase
      end

      if (upd_i.valid && upd_i.ready) begin
        got_beat = '{upd_i.flush_pulse, upd_i.rate_update, upd_i.rate_code,
                     upd_i.mode_update, upd_i.mode_code, upd_i.next_channel};
        if (pending_updates.size() == 0) begin
          errs++;
          if (errs <= 10) $display("%0t: update beat with nothing expected: %p", $time, got_beat);
        end else begin
          exp_beat = pending_updates.pop_front();
          if (got_beat !== exp_beat) begin
            errs++;
            if (errs <= 10) $display("%0t: update mismatch\n  expected %p\n  actual   %p",
                                     $time, exp_beat, got_beat);
          end
        end
      end

      if (conv_i.valid && conv_i.ready) begin
        exp_beat = '0;
        if (skip_conv) begin
          if (cur_chan == CH_RATE && last_rate < flush_thr) exp_beat.flush = 1'b1;
          skip_conv = 1'b0;
        end else begin
          v = conv_i.conversion_result[SampleW-1:2];
          if (cur_chan == CH_RATE) begin
            if (v != last_rate) begin
              exp_beat.rate_up = 1'b1;
              exp_beat.rate_code = calibrate_rate(v);
            end
            last_rate = v;
          end else begin
            if (v != last_mode) begin
              exp_beat.mode_up = 1'b1;
              exp_beat.mode_code = v;
            end
            last_mode = v;
          end
          scan_idx = ~scan_idx;
          cur_chan = scan_idx ? CH_RATE : CH_MODE;
          skip_conv = 1'b1;
        end
        exp_beat.next_ch = cur_chan;
        pending_updates.push_back(exp_beat);
      end

      pending_o <= pending_updates.size();
      err_count_o <= errs;
    end
  end

  initial begin
    pending_o = 0;
    err_count_o = 0;
  end

endmodule

>>> bench/testbench.sv
// top of the bench: clock, reset, conversion and register stimulus, stall control and verdict

module testbench;
  import asu_pkg::*;

  localparam int unsigned NumPoints  = 5;
  localparam int          QuietLimit = 4000;
  localparam int          PhaseItems = 72;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;
  int                  chk_pending;
  int                  chk_errs;
  int                  quiet;
  idle_e               stall_mode;

  asu_in_if  conv ();
  asu_out_if upd ();

  adc_scan_calibrated_update #(.CURVE_POINTS(NumPoints)) u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .conv_i  (conv),
    .upd_o   (upd),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  asu_checker #(.CURVE_POINTS(NumPoints)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .conv_i      (conv),
    .upd_i       (upd),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .pending_o   (chk_pending),
    .err_count_o (chk_errs)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // sink side stalls
  always @(negedge clk) begin
    case (stall_mode)
      IDLE_RECV: upd.ready <= ($urandom_range(0, 99) >= 76);
      IDLE_BOTH: upd.ready <= ($urandom_range(0, 99) >= 7);
      default:   upd.ready <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((conv.valid && conv.ready) || (upd.valid && upd.ready)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= QuietLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_conversion(input logic [SampleW-1:0] smp);
    @(negedge clk);
    while ((stall_mode == IDLE_SEND && $urandom_range(0, 99) < 76) ||
           (stall_mode == IDLE_BOTH && $urandom_range(0, 99) < 7)) begin
      conv.valid <= 1'b0;
      @(negedge clk);
    end
    conv.valid <= 1'b1;
    conv.conversion_result <= smp;
    @(posedge clk);
    while (!conv.ready) @(posedge clk);
  endtask

  // hold off conversions until every update beat is back
  task automatic drain_updates();
    @(negedge clk);
    conv.valid <= 1'b0;
    while (chk_pending != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [RegIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [SampleW-1:0]   directed [23];
    logic [SampleW-1:0]   hist [4];
    logic [SampleW-1:0]   smp;
    logic [CfgDataW-1:0]  cfg_in [6];
    logic [CfgDataW-1:0]  cfg_out [6];
    logic [CfgDataW-1:0]  cfg_thr [6];
    logic [CurveRegW-1:0] cur_in;
    logic [ThrW-1:0]      cur_thr;
    idle_e                phase_mode [6];
    int                   sel;
    int                   b;

    rst_n = 1'b0;
    quiet = 0;
    stall_mode = IDLE_NONE;
    conv.valid = 1'b0;
    conv.conversion_result = '0;
    upd.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    directed = '{10'd0, 10'd1023, 10'd1023, 10'd5, 10'd0, 10'd0, 10'd3, 10'd512, 10'd1020,
                 10'd77, {8'd60, 2'd1}, 10'd0, 10'd1023, 10'd0, {8'd186, 2'd3}, 10'd0,
                 10'h155, 10'd0, {8'd187, 2'd0}, 10'h2AA, 10'h2AA, 10'd0, {8'd127, 2'd0}};
    hist = '{default: '0};
    phase_mode = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_RECV, IDLE_SEND};

    cfg_in[0] = 64'(CurveInRst);
    cfg_out[0] = 64'(CurveOutRst);
    cfg_thr[0] = 64'(FlushThrRst);
    cfg_in[1] = '0;
    cfg_out[1] = '0;
    cfg_thr[1] = '0;
    cfg_in[2] = '1;
    cfg_out[2] = '1;
    cfg_thr[2] = '1;
    // falling curve over rising inputs: negative slopes
    cfg_in[3] = 64'h00FF_C864_2800;
    cfg_out[3] = 64'h0000_1E64_C8FF;
    cfg_thr[3] = 64'd128;
    cfg_in[4] = {$urandom, $urandom};
    cfg_out[4] = {$urandom, $urandom};
    cfg_thr[4] = {$urandom, $urandom};
    // repeated breakpoints make zero-width segments, low values match no segment
    cfg_in[5] = 64'h00FF_8080_0A0A;
    cfg_out[5] = {$urandom, $urandom};
    cfg_thr[5] = 64'($urandom_range(1, 254));
    cur_in = CurveInRst;
    cur_thr = FlushThrRst;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_conversion(directed[i]);

    for (int k = 0; k < 6; k++) begin
      if (k > 0) begin
        drain_updates();
        cfg_write(REG_CURVE_IN, cfg_in[k]);
        cfg_write(REG_CURVE_OUT, cfg_out[k]);
        cfg_write(REG_FLUSH_THR, cfg_thr[k]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_in = cfg_in[k][CurveRegW-1:0];
        cur_thr = cfg_thr[k][ThrW-1:0];
      end
      stall_mode = phase_mode[k];

      for (int j = 0; j < PhaseItems; j++) begin
        sel = int'($urandom_range(0, 9));
        case (sel)
          0, 1, 2, 3: smp = 10'($urandom_range(0, 1023));
          // recent values tend to match the stored one and give no update
          4, 5: smp = hist[$urandom_range(0, 3)];
          6, 7, 8: begin
            if (sel == 8) b = int'(cur_thr) - int'($urandom_range(0, 1));
            else b = int'((cur_in >> (8 * $urandom_range(0, 4))) & 40'hFF)
                     + int'($urandom_range(0, 2)) - 1;
            if (b < 0) b = 0;
            if (b > 255) b = 255;
            smp = {b[7:0], 2'($urandom_range(0, 3))};
          end
          default: smp = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
        endcase
        if (j == PhaseItems / 2 || $urandom_range(0, 59) == 0) drain_updates();
        send_conversion(smp);
        hist = '{smp, hist[0], hist[1], hist[2]};
      end
    end

    drain_updates();
    repeat (30) @(negedge clk);
    if (chk_errs == 0 && chk_pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
